FILE: design/dexp_pkg.sv
// ----------------------------------------------------------------------------
// Determinant excitation package
// Field widths, excitation type codes and shared helpers for the
// determinant excitation and phase core.
// ----------------------------------------------------------------------------
package dexp_pkg;

    localparam int DATA_W           = 64;   // width of one occupation string
    localparam int IDX_W            = 6;    // width of one orbital index
    localparam int FUNC_W           = 3;
    localparam int ORBITAL_BITS_DEF = 64;

    // Stream word layout.
    localparam int IN_TDATA_W  = 2 * DATA_W + 4 * IDX_W;        // 152, whole bytes
    localparam int OUT_BITS    = 2 * DATA_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;      // 136
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SINGLE_ALPHA = 3'd0,
        FUNC_SINGLE_BETA  = 3'd1,
        FUNC_DOUBLE_AA    = 3'd2,
        FUNC_DOUBLE_AB    = 3'd3,
        FUNC_DOUBLE_BB    = 3'd4
    } func_t;

    // Control carried alongside the first pipeline stage.
    typedef struct packed {
        logic type_ok;      // known type, indices in range, no repeated orbital in a same-spin double
        logic first_beta;   // first move acts on the beta string
        logic second_beta;  // second move acts on the beta string
        logic two_moves;    // double excitation
        logic corr;         // phase correction for a same-spin double
    } stage_ctrl_t;

    // True when x lies strictly between p and q.
    function automatic logic strictly_between(input logic [IDX_W-1:0] x,
                                              input logic [IDX_W-1:0] p,
                                              input logic [IDX_W-1:0] q);
        return ((x > p) && (x < q)) || ((x > q) && (x < p));
    endfunction

endpackage

FILE: design/determinant_excitation_phase_core.sv
// Three register stages lie between an accepted input word and its result word on m_tvalid.
// Throughput: one word per cycle unless stalled; each register stage holds
// its word while the stage after it is full and stalled, and fills bubbles.
// Reset (aresetn low, synchronous) clears the stage valid bits and the stage
// one control word; no clearing pass is needed and the core accepts input in
// the cycle after reset.
// ----------------------------------------------------------------------------
// Determinant excitation and phase core
// Applies a single or double excitation to an alpha/beta occupation pair,
// checks that it is allowed and gives the fermionic sign.
// ----------------------------------------------------------------------------
module determinant_excitation_phase_core #(
    parameter int ORBITAL_BITS = dexp_pkg::ORBITAL_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // alpha_bits, beta_bits, first_index, second_index, third_index, fourth_index
    input  logic [dexp_pkg::IN_TDATA_W-1:0]   s_tdata,
    // func
    input  logic [dexp_pkg::FUNC_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // new_alpha, new_beta, sign_negative, zero padding
    output logic [dexp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // valid_res
    output logic [0:0]                        m_tuser
);
    import dexp_pkg::*;

    localparam int W = ORBITAL_BITS;
    localparam logic [W-1:0]     ONE_W     = W'(1);
    localparam logic [IDX_W:0]   ORB_LIMIT = (IDX_W + 1)'(ORBITAL_BITS);

    // Input fields.
    logic [W-1:0]     in_alpha, in_beta;
    logic [IDX_W-1:0] idx_i, idx_j, idx_a, idx_b;

    assign in_alpha = s_tdata[W-1:0];
    assign in_beta  = s_tdata[DATA_W +: W];
    assign idx_i    = s_tdata[2*DATA_W +: IDX_W];
    assign idx_j    = s_tdata[2*DATA_W + IDX_W +: IDX_W];
    assign idx_a    = s_tdata[2*DATA_W + 2*IDX_W +: IDX_W];
    assign idx_b    = s_tdata[2*DATA_W + 3*IDX_W +: IDX_W];

    // Pipeline flow control.
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;
    assign m_tvalid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_tvalid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // ---------------- Stage 1: decode type, range checks, one-hot masks ----
    stage_ctrl_t      ctrl1_next, ctrl1_reg;
    logic [IDX_W-1:0] q1_idx;
    logic [W-1:0]     mp1_next, mq1_next, mp2_next, mq2_next;
    logic [W-1:0]     mp1_reg, mq1_reg, mp2_reg, mq2_reg;
    logic [W-1:0]     alpha1_reg, beta1_reg;
    logic             rng_i, rng_j, rng_a, rng_b;

    assign rng_i = ({1'b0, idx_i} < ORB_LIMIT);
    assign rng_j = ({1'b0, idx_j} < ORB_LIMIT);
    assign rng_a = ({1'b0, idx_a} < ORB_LIMIT);
    assign rng_b = ({1'b0, idx_b} < ORB_LIMIT);

    always_comb begin
        ctrl1_next = '0;
        q1_idx     = idx_a;
        unique case (func_t'(s_tuser))
            FUNC_SINGLE_ALPHA: begin
                ctrl1_next.type_ok = rng_i && rng_j;
                q1_idx             = idx_j;
            end
            FUNC_SINGLE_BETA: begin
                ctrl1_next.type_ok    = rng_i && rng_j;
                ctrl1_next.first_beta = 1'b1;
                q1_idx                = idx_j;
            end
            FUNC_DOUBLE_AA: begin
                ctrl1_next.type_ok   = rng_i && rng_j && rng_a && rng_b
                                       && (idx_i != idx_j) && (idx_a != idx_b);
                ctrl1_next.two_moves = 1'b1;
                ctrl1_next.corr      = strictly_between(idx_i, idx_j, idx_b)
                                       ^ strictly_between(idx_a, idx_j, idx_b);
            end
            FUNC_DOUBLE_AB: begin
                ctrl1_next.type_ok     = rng_i && rng_j && rng_a && rng_b;
                ctrl1_next.second_beta = 1'b1;
                ctrl1_next.two_moves   = 1'b1;
            end
            FUNC_DOUBLE_BB: begin
                ctrl1_next.type_ok     = rng_i && rng_j && rng_a && rng_b
                                         && (idx_i != idx_j) && (idx_a != idx_b);
                ctrl1_next.first_beta  = 1'b1;
                ctrl1_next.second_beta = 1'b1;
                ctrl1_next.two_moves   = 1'b1;
                ctrl1_next.corr        = strictly_between(idx_i, idx_j, idx_b)
                                         ^ strictly_between(idx_a, idx_j, idx_b);
            end
            default: begin
                ctrl1_next = '0;
            end
        endcase
    end

    // In a same-spin double the second move sees the string after the first.
    // Since i and a can never coincide with j or b once the occupancy checks
    // pass, that count equals the count on the original string, flipped once
    // for each of i and a lying strictly between j and b.
    assign mp1_next = ONE_W << idx_i;
    assign mq1_next = ONE_W << q1_idx;
    assign mp2_next = ctrl1_next.two_moves ? (ONE_W << idx_j) : '0;
    assign mq2_next = ctrl1_next.two_moves ? (ONE_W << idx_b) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
        end else if (adv1) begin
            ctrl1_reg <= ctrl1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            alpha1_reg <= in_alpha;
            beta1_reg  <= in_beta;
            mp1_reg    <= mp1_next;
            mq1_reg    <= mq1_next;
            mp2_reg    <= mp2_next;
            mq2_reg    <= mq2_next;
        end
    end

    // ---------------- Stage 2: occupancy, moved strings, phase masks -------
    logic [W-1:0] s1, s2;
    logic [W-1:0] clr_a, set_a, clr_b, set_b;
    logic [W-1:0] btw1_next, btw2_next, btw1_reg, btw2_reg;
    logic [W-1:0] na2_next, nb2_next, na2_reg, nb2_reg;
    logic         ok2_next, ok2_reg, corr2_reg;

    assign s1 = ctrl1_reg.first_beta  ? beta1_reg : alpha1_reg;
    assign s2 = ctrl1_reg.second_beta ? beta1_reg : alpha1_reg;

    assign ok2_next = ctrl1_reg.type_ok
                      && (|(s1 & mp1_reg)) && !(|(s1 & mq1_reg))
                      && (!ctrl1_reg.two_moves
                          || ((|(s2 & mp2_reg)) && !(|(s2 & mq2_reg))));

    // Bits strictly between source and target: the span [lo, hi) with lo removed.
    assign btw1_next = ((mp1_reg - ONE_W) ^ (mq1_reg - ONE_W)) & ~mp1_reg & ~mq1_reg & s1;
    assign btw2_next = ((mp2_reg - ONE_W) ^ (mq2_reg - ONE_W)) & ~mp2_reg & ~mq2_reg & s2;

    assign clr_a = (ctrl1_reg.first_beta ? '0 : mp1_reg) | (ctrl1_reg.second_beta ? '0 : mp2_reg);
    assign set_a = (ctrl1_reg.first_beta ? '0 : mq1_reg) | (ctrl1_reg.second_beta ? '0 : mq2_reg);
    assign clr_b = (ctrl1_reg.first_beta ? mp1_reg : '0) | (ctrl1_reg.second_beta ? mp2_reg : '0);
    assign set_b = (ctrl1_reg.first_beta ? mq1_reg : '0) | (ctrl1_reg.second_beta ? mq2_reg : '0);

    assign na2_next = (alpha1_reg & ~clr_a) | set_a;
    assign nb2_next = (beta1_reg  & ~clr_b) | set_b;

    always_ff @(posedge aclk) begin
        if (adv2) begin
            ok2_reg   <= ok2_next;
            corr2_reg <= ctrl1_reg.corr;
            btw1_reg  <= btw1_next;
            btw2_reg  <= btw2_next;
            na2_reg   <= na2_next;
            nb2_reg   <= nb2_next;
        end
    end

    // ---------------- Stage 3: parity reduction and result register --------
    logic              sign_next, sign_reg, valid_reg;
    logic [W-1:0]      na3_reg, nb3_reg;

    assign sign_next = (^btw1_reg) ^ (^btw2_reg) ^ corr2_reg;

    always_ff @(posedge aclk) begin
        if (adv3) begin
            valid_reg <= ok2_reg;
            sign_reg  <= ok2_reg && sign_next;
            na3_reg   <= ok2_reg ? na2_reg : '0;
            nb3_reg   <= ok2_reg ? nb2_reg : '0;
        end
    end

    assign m_tdata = {OUT_PAD_W'(0), sign_reg, DATA_W'(nb3_reg), DATA_W'(na3_reg)};
    assign m_tuser = valid_reg;

`ifndef ASSERT_OFF
    // A blocked or unknown excitation gives an all-zero word.
    a_blocked_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0))
        else $error("blocked excitation with non-zero result word");

    // Input is only refused when every stage holds a word.
    a_no_bubble_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input refused while the pipeline has a free stage");

    // A middle-stage word that cannot move on is kept.
    a_stage2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !adv2 |=> v2_reg && $stable(na2_reg) && $stable(ok2_reg))
        else $error("stalled stage two word lost or changed");

    // Result strings carry no bits above the orbital count.
    a_orbital_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[DATA_W-1:0] >> ORBITAL_BITS) == '0)
                     && ((m_tdata[2*DATA_W-1:DATA_W] >> ORBITAL_BITS) == '0))
        else $error("result string has bits beyond the orbital count");
`endif

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the determinant excitation and phase core
// Drives excitation words through the input stream and checks every result
// word against a predictor of the excited strings, the validity flag and the
// fermionic sign. A directed set comes first, then phases of random words
// with the sender and the receiver idling at different rates.
// ----------------------------------------------------------------------------
module tb;
    import dexp_pkg::*;

    localparam int          ORB_COUNT   = ORBITAL_BITS_DEF;
    localparam logic [63:0] ORB_MASK    = {64{1'b1}} >> (64 - ORB_COUNT);
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_WORDS = 300;
    localparam int          NO_AVOID    = 64;

    // Type codes that the core does not know.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_7 = 3'd7;

    typedef struct {
        logic [63:0] next_alpha;
        logic [63:0] next_beta;
        logic        allowed;
        logic        negative;
    } det_result_t;

    class excitation_scoreboard;
        det_result_t expected_dets[$];
        int unsigned mismatches;

        function bit between_parity(logic [63:0] s, int p, int q);
            int lo;
            int hi;
            bit par;
            lo  = (p < q) ? p : q;
            hi  = (p < q) ? q : p;
            par = 1'b0;
            for (int k = lo + 1; k < hi; k++) par ^= s[k];
            return par;
        endfunction

        function bit hop_single(logic [63:0] s, int p, int q,
                                output logic [63:0] ns, output bit par);
            ns  = s;
            par = 1'b0;
            if (p >= ORB_COUNT || q >= ORB_COUNT) return 1'b0;
            if (!s[p] || s[q]) return 1'b0;
            ns    = s;
            ns[p] = 1'b0;
            ns[q] = 1'b1;
            par   = between_parity(s, p, q);
            return 1'b1;
        endfunction

        // Same-spin double: i to a first, then j to b counted on the moved string.
        function bit hop_pair(logic [63:0] s, int i, int j, int a, int b,
                              output logic [63:0] ns, output bit par);
            logic [63:0] mid;
            ns  = s;
            par = 1'b0;
            if (i >= ORB_COUNT || j >= ORB_COUNT || a >= ORB_COUNT || b >= ORB_COUNT)
                return 1'b0;
            if (i == j || a == b) return 1'b0;
            if (!s[i] || !s[j] || s[a] || s[b]) return 1'b0;
            mid    = s;
            mid[i] = 1'b0;
            mid[a] = 1'b1;
            par    = between_parity(s, i, a) ^ between_parity(mid, j, b);
            ns     = mid;
            ns[j]  = 1'b0;
            ns[b]  = 1'b1;
            return 1'b1;
        endfunction

        function void note_input(logic [63:0] alpha, logic [63:0] beta,
                                 logic [FUNC_W-1:0] func,
                                 int i, int j, int a, int b);
            logic [63:0] al;
            logic [63:0] be;
            logic [63:0] na;
            logic [63:0] nb;
            bit          par;
            bit          p2;
            bit          ok;
            det_result_t r;
            al  = alpha & ORB_MASK;
            be  = beta & ORB_MASK;
            na  = al;
            nb  = be;
            par = 1'b0;
            p2  = 1'b0;
            case (func)
                FUNC_SINGLE_ALPHA: ok = hop_single(al, i, j, na, par);
                FUNC_SINGLE_BETA:  ok = hop_single(be, i, j, nb, par);
                FUNC_DOUBLE_AA:    ok = hop_pair(al, i, j, a, b, na, par);
                FUNC_DOUBLE_AB: begin
                    ok = hop_single(al, i, a, na, par);
                    if (ok) ok = hop_single(be, j, b, nb, p2);
                    par ^= p2;
                end
                FUNC_DOUBLE_BB:    ok = hop_pair(be, i, j, a, b, nb, par);
                default:           ok = 1'b0;
            endcase
            if (ok) begin
                r.next_alpha = na & ORB_MASK;
                r.next_beta  = nb & ORB_MASK;
                r.allowed    = 1'b1;
                r.negative   = par;
            end else begin
                r.next_alpha = '0;
                r.next_beta  = '0;
                r.allowed    = 1'b0;
                r.negative   = 1'b0;
            end
            expected_dets.push_back(r);
        endfunction

        function void check_result(logic [63:0] alpha, logic [63:0] beta,
                                   logic allowed, logic negative);
            det_result_t e;
            if (expected_dets.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected, alpha %h beta %h valid %b",
                         $time, alpha, beta, allowed);
                return;
            end
            e = expected_dets.pop_front();
            if (alpha !== e.next_alpha) begin
                mismatches++;
                $display("%0t: new_alpha expected %h actual %h", $time, e.next_alpha, alpha);
            end
            if (beta !== e.next_beta) begin
                mismatches++;
                $display("%0t: new_beta expected %h actual %h", $time, e.next_beta, beta);
            end
            if (allowed !== e.allowed) begin
                mismatches++;
                $display("%0t: valid_res expected %b actual %b", $time, e.allowed, allowed);
            end
            if (negative !== e.negative) begin
                mismatches++;
                $display("%0t: sign_negative expected %b actual %b",
                         $time, e.negative, negative);
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [FUNC_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;

    excitation_scoreboard sb = new();
    int                   sender_idle_pct;
    int                   recv_stall_pct;
    int unsigned          cycle_count;

    determinant_excitation_phase_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("[determinant_excitation_phase_core] ERROR");
                $finish;
            end
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Inputs and m_tready only change at rising edges, so a word seen with
    // valid and ready high at the falling edge is taken at the next rise.
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[63:0], m_tdata[127:64], m_tuser[0], m_tdata[128]);
    end

    task automatic send_excitation(logic [63:0] alpha, logic [63:0] beta,
                                   logic [FUNC_W-1:0] func, int i, int j, int a, int b);
        int gap;
        bit taken;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {b[5:0], a[5:0], j[5:0], i[5:0], beta, alpha};
        do begin
            @(negedge aclk);
            taken = s_tready;
            if (!taken) @(posedge aclk);
        end while (!taken);
        sb.note_input(alpha, beta, func, i, j, a, b);
        @(posedge aclk);
    endtask

    // Hold the sender off until every outstanding result word has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_dets.size() != 0);
    endtask

    function automatic logic [63:0] random_string();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1:    r &= {$urandom, $urandom};
            2, 3:    r |= {$urandom, $urandom};
            4:       r = ~({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
            5:       r = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: ;
        endcase
        return r;
    endfunction

    // Random orbital holding the wanted occupation, other than the avoided one.
    function automatic int pick_orbital(logic [63:0] s, bit want, int avoid);
        int start;
        int p;
        start = $urandom_range(63);
        for (int k = 0; k < 64; k++) begin
            p = (start + k) % 64;
            if (s[p] == want && p != avoid) return p;
        end
        return start;
    endfunction

    task automatic send_random();
        logic [63:0]       alpha;
        logic [63:0]       beta;
        logic [63:0]       src;
        logic [FUNC_W-1:0] func;
        int                idx[4];
        alpha = random_string();
        beta  = random_string();
        func  = ($urandom_range(9) == 0) ? FUNC_W'(FUNC_UNUSED_5 + $urandom_range(2))
                                         : FUNC_W'($urandom_range(4));
        for (int k = 0; k < 4; k++) idx[k] = $urandom_range(63);
        if ($urandom_range(99) < 80) begin
            src = (func == FUNC_SINGLE_BETA || func == FUNC_DOUBLE_BB) ? beta : alpha;
            case (func)
                FUNC_SINGLE_ALPHA, FUNC_SINGLE_BETA: begin
                    idx[0] = pick_orbital(src, 1'b1, NO_AVOID);
                    idx[1] = pick_orbital(src, 1'b0, NO_AVOID);
                end
                FUNC_DOUBLE_AA, FUNC_DOUBLE_BB: begin
                    idx[0] = pick_orbital(src, 1'b1, NO_AVOID);
                    idx[1] = pick_orbital(src, 1'b1, idx[0]);
                    idx[2] = pick_orbital(src, 1'b0, NO_AVOID);
                    idx[3] = pick_orbital(src, 1'b0, idx[2]);
                end
                FUNC_DOUBLE_AB: begin
                    idx[0] = pick_orbital(alpha, 1'b1, NO_AVOID);
                    idx[2] = pick_orbital(alpha, 1'b0, NO_AVOID);
                    idx[1] = pick_orbital(beta, 1'b1, NO_AVOID);
                    idx[3] = pick_orbital(beta, 1'b0, NO_AVOID);
                end
                default: ;
            endcase
            // Now and then break an otherwise sound excitation.
            if ($urandom_range(99) < 12) begin
                if ($urandom_range(1) == 1)
                    idx[2'($urandom_range(3))] = idx[2'($urandom_range(3))];
                else
                    idx[2'($urandom_range(3))] = $urandom_range(63);
            end
        end
        send_excitation(alpha, beta, func, idx[0], idx[1], idx[2], idx[3]);
    endtask

    initial begin
        int send_pct[4];
        int stall_pct[4];
        send_pct  = '{0, 69, 0, 14};
        stall_pct = '{0, 0, 69, 14};
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words: extremes of strings and indices, every type and the
        // blocked cases.
        send_excitation(64'h5555_5555_5555_5555, '0, FUNC_SINGLE_ALPHA, 0, 63, 0, 0);
        send_excitation(64'hFFFF_FFFF_FFFF_FFFE, '0, FUNC_SINGLE_ALPHA, 63, 0, 63, 63);
        send_excitation('1, '1, FUNC_SINGLE_ALPHA, 7, 7, 0, 0);
        send_excitation(64'h0000_0000_0000_00F0, '0, FUNC_SINGLE_ALPHA, 2, 40, 0, 0);
        send_excitation(64'h0000_0000_0000_00F0, '0, FUNC_SINGLE_ALPHA, 4, 5, 0, 0);
        send_excitation(64'h0123_4567_89AB_CDEF, 64'h0000_0000_0000_0020,
                        FUNC_SINGLE_BETA, 5, 6, 63, 63);
        send_excitation('0, 64'h8000_0000_0000_0001, FUNC_SINGLE_BETA, 63, 30, 0, 0);
        send_excitation(64'h0000_0000_0000_0005, '0, FUNC_DOUBLE_AA, 0, 2, 4, 6);
        send_excitation(64'h0000_0000_0000_0005, '0, FUNC_DOUBLE_AA, 0, 0, 4, 6);
        send_excitation(64'h0000_0000_0000_0005, '0, FUNC_DOUBLE_AA, 0, 2, 4, 4);
        send_excitation(64'h7FFF_FFFF_FFFF_FFFC, '0, FUNC_DOUBLE_AA, 62, 2, 0, 63);
        send_excitation(64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0,
                        FUNC_DOUBLE_AB, 0, 63, 60, 0);
        send_excitation(64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0,
                        FUNC_DOUBLE_AB, 0, 3, 60, 5);
        send_excitation('0, 64'hFFFF_FFFF_FFFF_FFF3, FUNC_DOUBLE_BB, 0, 63, 2, 3);
        send_excitation('0, 64'hFFFF_FFFF_FFFF_FFF3, FUNC_DOUBLE_BB, 0, 63, 2, 4);
        send_excitation('1, '1, FUNC_DOUBLE_BB, 1, 2, 3, 4);
        send_excitation(64'h0000_0000_0000_0001, '0, FUNC_UNUSED_5, 0, 1, 2, 3);
        send_excitation('1, '0, FUNC_UNUSED_6, 63, 0, 0, 0);
        send_excitation('1, '1, FUNC_UNUSED_7, 63, 63, 63, 63);
        send_excitation('0, '0, FUNC_SINGLE_ALPHA, 0, 1, 0, 0);
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = send_pct[ph];
            recv_stall_pct  = stall_pct[ph];
            repeat (PHASE_WORDS) send_random();
            drain_results();
        end

        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_dets.size() == 0)
            $display("[determinant_excitation_phase_core] OK");
        else
            $display("[determinant_excitation_phase_core] ERROR");
        $finish;
    end
endmodule

FILE: files.f
design/dexp_pkg.sv
design/determinant_excitation_phase_core.sv
tb/tb.sv
